// File: rtl/http_message_delimiter_assert.svh
// Assertion macros used by the checker file.
`ifndef HTTP_MESSAGE_DELIMITER_ASSERT_SVH
`define HTTP_MESSAGE_DELIMITER_ASSERT_SVH

// cond must hold at every edge out of reset.
`define HMD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge.
`define HMD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante at one edge implies cons at the next edge.
`define HMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hmd_pkg.sv
`default_nettype none

package hmd_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_C = 8'h43;

  // "Content-Length"
  localparam logic [3:0] KW_LEN = 4'd14;

  // last three bytes before the final LF of CR LF CR LF
  localparam logic [23:0] HDR_END_TAIL   = 24'h0D0A0D;
  // last four bytes before the final LF of '0' CR LF CR LF
  localparam logic [31:0] CHUNK_END_TAIL = 32'h300D0A0D;

  localparam logic [31:0] REM_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    NUM_SKIP,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        in_body;
    logic        header_end;
    logic        message_end;
    logic        chunked_mode;
    logic [31:0] body_remaining;
  } out_item_t;

  // length event raised at the CR of a Content-Length line
  typedef struct packed {
    logic wr;
    logic known;
  } len_upd_t;

  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

// File: rtl/hmd_stream_if.sv
`default_nettype none

interface hmd_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/http_message_delimiter.sv
// Channel   Dir  Payload                                       Role
// in_chan   in   data_byte[7:0]                                raw message bytes
// out_chan  out  byte_out, in_body, header_end, message_end,   framed bytes, one per
//                chunked_mode, body_remaining[31:0]            input byte
//
// One transfer per cycle sustained, in and out, while out_chan.ready stays high; a byte's
// result is offered on out_chan after it passes the input stage and then the result stage.
// The framing update in hmd_framer holds the saturating multiply-by-ten of the length.
// rst_n (synchronous) clears both pipeline stages and all framing state.
// With out_chan.ready low the result holds; the input stage takes one more byte and
// then drops in_chan.ready until the result moves.
`default_nettype none

module http_message_delimiter #(
  parameter int LENGTH_BITS = 32
) (
  input wire logic     clk,
  input wire logic     rst_n,
  hmd_stream_if.sink   in_chan,
  hmd_stream_if.source out_chan
);

  // input stage
  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  // result stage
  logic               out_valid_r;
  hmd_pkg::out_item_t out_item_r;

  logic               s1_fire;
  logic               in_fire;
  hmd_pkg::out_item_t framed;

  // input stage moves on when the result register is empty or being drained
  assign s1_fire       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // framing state advances once per byte, at the transfer into the result register
  hmd_framer #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .data_byte (in_byte_r),
    .result    (framed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (s1_fire) begin
        in_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_chan.payload.data_byte;
    end
    if (s1_fire) begin
      out_item_r <= framed;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

`default_nettype wire

// File: rtl/hmd_line_parser.sv
`default_nettype none

// Per-line header scan: keyword match, first colon, atoi-style number.
module hmd_line_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   clear,
  input  wire logic [7:0]             data_byte,
  output hmd_pkg::len_upd_t           len_upd,
  output logic [LENGTH_BITS-1:0]      len_value
);

  localparam int PW = LENGTH_BITS + 4;

  logic [3:0]             kw_prog_r, kw_prog_nxt;
  logic                   kw_seen_r, kw_seen_nxt;
  logic                   colon_r, colon_nxt;
  hmd_pkg::num_phase_t    phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [LENGTH_BITS-1:0] val_r, val_nxt;

  logic                   is_dig;
  logic [3:0]             digit;
  logic [LENGTH_BITS-1:0] acc_base;
  logic [PW-1:0]          acc_prod;
  logic [LENGTH_BITS-1:0] acc_val;
  logic                   neg_value;

  assign is_dig = (data_byte >= hmd_pkg::CH_ZERO) && (data_byte <= hmd_pkg::CH_NINE);
  assign digit  = 4'(data_byte - hmd_pkg::CH_ZERO);

  // v*10 + d; overflow past LENGTH_BITS saturates
  assign acc_base = (phase_r == hmd_pkg::NUM_SKIP) ? '0 : val_r;
  assign acc_prod = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + PW'(digit);
  assign acc_val  = (acc_prod[PW-1:LENGTH_BITS] != 4'b0) ? '1 : acc_prod[LENGTH_BITS-1:0];

  assign neg_value     = neg_r && (val_r != '0);
  assign len_upd.wr    = step && (data_byte == hmd_pkg::CH_CR) && kw_seen_r && colon_r;
  assign len_upd.known = !neg_value;
  assign len_value     = neg_value ? '0 : val_r;

  always_comb begin
    kw_prog_nxt = kw_prog_r;
    kw_seen_nxt = kw_seen_r;
    colon_nxt   = colon_r;
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    val_nxt     = val_r;
    if (clear || (step && (data_byte == hmd_pkg::CH_LF))) begin
      kw_prog_nxt = '0;
      kw_seen_nxt = 1'b0;
      colon_nxt   = 1'b0;
      phase_nxt   = hmd_pkg::NUM_SKIP;
      neg_nxt     = 1'b0;
      val_nxt     = '0;
    end else if (step) begin
      if (!kw_seen_r) begin
        if ((kw_prog_r < hmd_pkg::KW_LEN) && (data_byte == hmd_pkg::kw_char(kw_prog_r))) begin
          if (kw_prog_r == hmd_pkg::KW_LEN - 4'd1) begin
            kw_seen_nxt = 1'b1;
            kw_prog_nxt = '0;
          end else begin
            kw_prog_nxt = kw_prog_r + 4'd1;
          end
        end else begin
          kw_prog_nxt = (data_byte == hmd_pkg::CH_UPPER_C) ? 4'd1 : 4'd0;
        end
      end
      if (!colon_r) begin
        if (data_byte == hmd_pkg::CH_COLON) begin
          colon_nxt = 1'b1;
          phase_nxt = hmd_pkg::NUM_SKIP;
          neg_nxt   = 1'b0;
          val_nxt   = '0;
        end
      end else begin
        unique case (phase_r)
          hmd_pkg::NUM_SKIP: begin
            priority if (hmd_pkg::is_space(data_byte)) begin
              phase_nxt = hmd_pkg::NUM_SKIP;
            end else if (data_byte == hmd_pkg::CH_PLUS) begin
              phase_nxt = hmd_pkg::NUM_SIGN;
            end else if (data_byte == hmd_pkg::CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = hmd_pkg::NUM_SIGN;
            end else if (is_dig) begin
              val_nxt   = acc_val;
              phase_nxt = hmd_pkg::NUM_DIGITS;
            end else begin
              phase_nxt = hmd_pkg::NUM_DONE;
            end
          end
          hmd_pkg::NUM_SIGN, hmd_pkg::NUM_DIGITS: begin
            if (is_dig) begin
              val_nxt   = acc_val;
              phase_nxt = hmd_pkg::NUM_DIGITS;
            end else begin
              phase_nxt = hmd_pkg::NUM_DONE;
            end
          end
          hmd_pkg::NUM_DONE: begin
            phase_nxt = hmd_pkg::NUM_DONE;
          end
          default: begin
            phase_nxt = hmd_pkg::NUM_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_prog_r <= '0;
      kw_seen_r <= 1'b0;
      colon_r   <= 1'b0;
      phase_r   <= hmd_pkg::NUM_SKIP;
      neg_r     <= 1'b0;
      val_r     <= '0;
    end else begin
      kw_prog_r <= kw_prog_nxt;
      kw_seen_r <= kw_seen_nxt;
      colon_r   <= colon_nxt;
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      val_r     <= val_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hmd_framer.sv
`default_nettype none

// Message-level framing state and per-byte result.
module hmd_framer #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  output hmd_pkg::out_item_t result
);

  localparam int OW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  logic [31:0]            recent_r, recent_nxt;
  logic [2:0]             seen_r, seen_nxt;
  logic                   hdr_done_r, hdr_done_nxt;
  logic                   chunked_r, chunked_nxt;
  logic                   len_known_r, len_known_nxt;
  logic [LENGTH_BITS-1:0] len_left_r, len_left_nxt;

  hmd_pkg::len_upd_t      len_upd;
  logic [LENGTH_BITS-1:0] len_value;
  logic                   parse_step;
  logic                   msg_end;
  logic                   hdr_end;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [LENGTH_BITS-1:0] rem_src;

  assign parse_step = step && !hdr_done_r;

  hmd_line_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_line_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (parse_step),
    .clear     (step && msg_end),
    .data_byte (data_byte),
    .len_upd   (len_upd),
    .len_value (len_value)
  );

  function automatic logic [31:0] sat32(input logic [LENGTH_BITS-1:0] v);
    logic [OW-1:0] ext;
    ext = OW'(v);
    return (ext > OW'(hmd_pkg::REM_MAX)) ? hmd_pkg::REM_MAX : ext[31:0];
  endfunction

  assign hdr_end = !hdr_done_r && (seen_r >= 3'd3) && (data_byte == hmd_pkg::CH_LF) &&
                   (recent_r[23:0] == hmd_pkg::HDR_END_TAIL);
  assign left_dec = (len_left_r != '0) ? len_left_r - LENGTH_BITS'(1) : '0;
  assign rem_src  = hdr_end ? len_left_r : left_dec;

  always_comb begin
    result.byte_out       = data_byte;
    result.in_body        = hdr_done_r;
    result.header_end     = hdr_end;
    result.message_end    = 1'b0;
    result.chunked_mode   = 1'b0;
    result.body_remaining = '0;
    if (hdr_end) begin
      if (len_known_r) begin
        result.body_remaining = sat32(rem_src);
        result.message_end    = (len_left_r == '0);
      end else begin
        result.chunked_mode = 1'b1;
      end
    end else if (hdr_done_r) begin
      if (!chunked_r) begin
        result.body_remaining = sat32(rem_src);
        result.message_end    = (left_dec == '0);
      end else begin
        result.chunked_mode = 1'b1;
        result.message_end  = (seen_r >= 3'd4) && (data_byte == hmd_pkg::CH_LF) &&
                              (recent_r == hmd_pkg::CHUNK_END_TAIL);
      end
    end
  end

  assign msg_end = result.message_end;

  always_comb begin
    recent_nxt    = recent_r;
    seen_nxt      = seen_r;
    hdr_done_nxt  = hdr_done_r;
    chunked_nxt   = chunked_r;
    len_known_nxt = len_known_r;
    len_left_nxt  = len_left_r;
    if (step) begin
      if (msg_end) begin
        recent_nxt    = '0;
        seen_nxt      = '0;
        hdr_done_nxt  = 1'b0;
        chunked_nxt   = 1'b0;
        len_known_nxt = 1'b0;
        len_left_nxt  = '0;
      end else begin
        recent_nxt = {recent_r[23:0], data_byte};
        seen_nxt   = (seen_r != 3'd7) ? seen_r + 3'd1 : seen_r;
        if (len_upd.wr) begin
          len_known_nxt = len_upd.known;
          len_left_nxt  = len_value;
        end
        if (hdr_end) begin
          hdr_done_nxt = 1'b1;
          chunked_nxt  = !len_known_r;
        end else if (hdr_done_r && !chunked_r) begin
          len_left_nxt = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= '0;
      seen_r      <= '0;
      hdr_done_r  <= 1'b0;
      chunked_r   <= 1'b0;
      len_known_r <= 1'b0;
      len_left_r  <= '0;
    end else begin
      recent_r    <= recent_nxt;
      seen_r      <= seen_nxt;
      hdr_done_r  <= hdr_done_nxt;
      chunked_r   <= chunked_nxt;
      len_known_r <= len_known_nxt;
      len_left_r  <= len_left_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hmd_checker.sv
`default_nettype none

`include "http_message_delimiter_assert.svh"

module hmd_assert_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hmd_pkg::out_item_t out_item
);

  `HMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

  `HMD_ASSERT_SAME(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

  `HMD_ASSERT_ALWAYS(a_hend_hdr, !(out_valid && out_item.header_end && out_item.in_body), "header end flagged as body")

  `HMD_ASSERT_SAME(a_hdr_quiet, out_valid && !out_item.in_body && !out_item.header_end, !out_item.chunked_mode && !out_item.message_end && (out_item.body_remaining == 32'd0), "header byte carries body status")

  `HMD_ASSERT_SAME(a_len_end, out_valid && out_item.message_end && !out_item.chunked_mode, out_item.body_remaining == 32'd0, "length message ended with bytes left")

endmodule

bind http_message_delimiter hmd_assert_checker u_hmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.payload)
);

`default_nettype wire
